FILE: hw/rtl/key_value_line_tokenizer_assert.svh
// Assertion macros shared by the tokenizer RTL files.
`ifndef KEY_VALUE_LINE_TOKENIZER_ASSERT_SVH
`define KEY_VALUE_LINE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KVLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("kvlt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KVLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("kvlt assertion failed");

`endif

FILE: hw/rtl/kvlt_pkg.sv
// Package with types and constants of the key/value line tokenizer.
package kvlt_pkg;

  localparam int DATA_W = 8;
  localparam int LEN_W = 8;
  localparam int MAX_TOKEN_LENGTH_DEF = 255;

  // Characters the parser reacts to
  localparam logic [DATA_W-1:0] CH_NUL   = 8'h00;
  localparam logic [DATA_W-1:0] CH_HASH  = 8'h23;
  localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;

  // Byte tags
  localparam logic [1:0] KIND_SKIP  = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;

  // One result item
  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic [1:0]        kind;
    logic              pair_end;
    logic [LEN_W-1:0]  key_len;
    logic [LEN_W-1:0]  val_len;
    logic              stream_end;
    logic              error;
  } res_t;

endpackage

FILE: hw/rtl/kvlt_ifs.sv
// Valid/ready channel interfaces for the tokenizer input and result items.
interface kvlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output data, output last, input ready);
  modport sink (input valid, input data, input last, output ready);
endinterface

interface kvlt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic [1:0] kind;
  logic       pair_end;
  logic [7:0] key_len;
  logic [7:0] val_len;
  logic       stream_end;
  logic       error;

  modport source (output valid, output data_out, output kind, output pair_end,
                  output key_len, output val_len, output stream_end,
                  output error, input ready);
  modport sink (input valid, input data_out, input kind, input pair_end,
                input key_len, input val_len, input stream_end,
                input error, output ready);
endinterface

FILE: hw/rtl/kvlt_parse.sv
// Line parser: phase and token counters, next result computed per item.
`include "key_value_line_tokenizer_assert.svh"

module kvlt_parse #(
  parameter int MaxTokenLength = kvlt_pkg::MAX_TOKEN_LENGTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [kvlt_pkg::DATA_W-1:0]   data_i,
  input  logic                          last_i,
  output kvlt_pkg::res_t                res_o
);
  import kvlt_pkg::*;

  localparam int CntW = $clog2(MaxTokenLength + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxTokenLength);

  typedef enum logic [2:0] {
    PH_SKIP, PH_COMMENT, PH_KEY, PH_GAP, PH_VALUE, PH_TRAIL, PH_DONE, PH_ERROR
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] key_cnt_q, key_cnt_d;
  logic [CntW-1:0] val_cnt_q, val_cnt_d;

  logic        blank, line_end, content, ended, pair;
  logic [1:0]  kind;
  logic [15:0] key_ext, val_ext;

  assign blank    = (data_i == CH_SPACE) || (data_i == CH_TAB);
  assign line_end = (data_i == CH_LF) || (data_i == CH_CR);
  assign content  = !blank && !line_end;

  // Phase transition for one byte
  always_comb begin
    phase_d   = phase_q;
    key_cnt_d = key_cnt_q;
    val_cnt_d = val_cnt_q;
    kind      = KIND_SKIP;
    pair      = 1'b0;
    ended     = 1'b0;
    if (phase_q != PH_DONE && phase_q != PH_ERROR) begin
      if (data_i == CH_NUL) begin
        ended = 1'b1;
      end else begin
        case (phase_q)
          PH_SKIP: begin
            if (data_i == CH_HASH) begin
              phase_d = PH_COMMENT;
            end else if (content) begin
              phase_d   = PH_KEY;
              key_cnt_d = CntW'(1);
              kind      = KIND_KEY;
            end
          end
          PH_COMMENT: begin
            if (line_end) phase_d = PH_SKIP;
          end
          PH_KEY: begin
            if (content) begin
              key_cnt_d = (key_cnt_q < CntMax) ? key_cnt_q + 1'b1 : CntMax;
              kind      = KIND_KEY;
            end else if (blank) begin
              phase_d = PH_GAP;
            end else begin
              phase_d = PH_ERROR;
            end
          end
          PH_GAP: begin
            if (content) begin
              phase_d   = PH_VALUE;
              val_cnt_d = CntW'(1);
              kind      = KIND_VALUE;
            end else if (line_end) begin
              phase_d = PH_ERROR;
            end
          end
          PH_VALUE: begin
            if (content) begin
              val_cnt_d = (val_cnt_q < CntMax) ? val_cnt_q + 1'b1 : CntMax;
              kind      = KIND_VALUE;
            end else begin
              pair    = 1'b1;
              phase_d = blank ? PH_TRAIL : PH_SKIP;
            end
          end
          PH_TRAIL: begin
            if (line_end) phase_d = PH_SKIP;
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
        if (last_i && phase_d != PH_ERROR) ended = 1'b1;
      end
      // End of stream: key or gap open is malformed, value completes
      if (ended) begin
        if (phase_d == PH_KEY || phase_d == PH_GAP) begin
          phase_d = PH_ERROR;
        end else begin
          if (phase_d == PH_VALUE) pair = 1'b1;
          phase_d = PH_DONE;
        end
      end
    end
  end

  // Lengths clamp to the 8-bit report width
  assign key_ext = 16'(key_cnt_d);
  assign val_ext = 16'(val_cnt_d);

  always_comb begin
    res_o.data_out   = data_i;
    res_o.kind       = kind;
    res_o.pair_end   = pair;
    res_o.key_len    = '0;
    res_o.val_len    = '0;
    if (pair) begin
      res_o.key_len = (key_ext > 16'd255) ? 8'hFF : key_ext[LEN_W-1:0];
      res_o.val_len = (val_ext > 16'd255) ? 8'hFF : val_ext[LEN_W-1:0];
    end
    res_o.stream_end = (phase_d == PH_DONE);
    res_o.error      = (phase_d == PH_ERROR);
  end

  // Parser state, advanced once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SKIP;
      key_cnt_q <= '0;
      val_cnt_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      key_cnt_q <= key_cnt_d;
      val_cnt_q <= val_cnt_d;
    end
  end

  `KVLT_ASSERT_NEXT(a_error_sticky, clk_i, rst_ni, phase_q == PH_ERROR, phase_q == PH_ERROR)
  `KVLT_ASSERT_NEXT(a_done_sticky, clk_i, rst_ni, phase_q == PH_DONE, phase_q == PH_DONE)
  `KVLT_ASSERT_NOW(a_gap_has_key, clk_i, rst_ni,
                   phase_q == PH_GAP || phase_q == PH_VALUE, key_cnt_q != '0)

endmodule

FILE: hw/rtl/key_value_line_tokenizer.sv
// Top level of the key/value line tokenizer: input register, parser, result register.
// Takes one text byte per item and returns one tagged result item per byte, in
// order. Sustained rate is one item per clock while results are taken; an accepted
// byte passes through the input register, then the result register, and the
// parser's phase update sits between the two. Input ready falls only when both
// registers are full and the result is not being taken. Token lengths count up to
// MAX_TOKEN_LENGTH and are reported clamped to 255; once the stream has ended or
// an error is flagged, that status stays until reset.
`include "key_value_line_tokenizer_assert.svh"

module key_value_line_tokenizer #(
  parameter int MAX_TOKEN_LENGTH = kvlt_pkg::MAX_TOKEN_LENGTH_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  kvlt_in_if.sink     in_i,
  kvlt_out_if.source  out_o
);
  import kvlt_pkg::*;

  logic              in_valid_q;
  logic [DATA_W-1:0] in_data_q;
  logic              in_last_q;
  logic              out_valid_q;
  res_t              res_q, res_d;
  logic              advance;

  // Item moves to the result register when it is empty or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_data_q <= in_i.data;
      in_last_q <= in_i.last;
    end
  end

  kvlt_parse #(
    .MaxTokenLength(MAX_TOKEN_LENGTH)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .data_i (in_data_q),
    .last_i (in_last_q),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.data_out   = res_q.data_out;
  assign out_o.kind       = res_q.kind;
  assign out_o.pair_end   = res_q.pair_end;
  assign out_o.key_len    = res_q.key_len;
  assign out_o.val_len    = res_q.val_len;
  assign out_o.stream_end = res_q.stream_end;
  assign out_o.error      = res_q.error;

  `KVLT_ASSERT_NOW(a_pair_has_key, clk_i, rst_ni,
                   out_o.valid && out_o.pair_end, out_o.key_len != '0)
  `KVLT_ASSERT_NOW(a_pair_not_key, clk_i, rst_ni,
                   out_o.valid && out_o.pair_end, out_o.kind != KIND_KEY)
  `KVLT_ASSERT_NOW(a_end_xor_error, clk_i, rst_ni,
                   out_o.valid, !(out_o.stream_end && out_o.error))
  `KVLT_ASSERT_NOW(a_ready_when_drained, clk_i, rst_ni, !out_valid_q, in_i.ready)

endmodule
